// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define SC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/core/sc1aq_pkg.sv =====
// ----------------------------------------------------------------------------
// sc1aq_pkg
// Shared constants, register indexes and key tables for the Set 1 scancode
// to character decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sc1aq_pkg;

  // Default ring size; the ring holds one character less than its depth.
  localparam int unsigned RingDepthDefault = 256;
  // Make codes at or above this value have no table entry.
  localparam int unsigned TableEntries = 89;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgUpArrow    = 2'd0,
    CfgDownArrow  = 2'd1,
    CfgLeftArrow  = 2'd2,
    CfgRightArrow = 2'd3
  } cfg_reg_e;

  // Reset values of the arrow key codes.
  localparam logic [7:0] UpArrowReset    = 8'd128;
  localparam logic [7:0] DownArrowReset  = 8'd129;
  localparam logic [7:0] LeftArrowReset  = 8'd130;
  localparam logic [7:0] RightArrowReset = 8'd131;

  // Special scancode bytes.
  localparam logic [7:0] ScPrefixExt = 8'hE0;
  localparam logic [7:0] ScCtrlMake  = 8'h1D;
  localparam logic [7:0] ScCtrlBreak = 8'h9D;
  localparam logic [6:0] KeyArrowUp    = 7'h48;
  localparam logic [6:0] KeyArrowDown  = 7'h50;
  localparam logic [6:0] KeyArrowLeft  = 7'h4B;
  localparam logic [6:0] KeyArrowRight = 7'h4D;
  localparam logic [6:0] KeyShiftLeft  = 7'h2A;
  localparam logic [6:0] KeyShiftRight = 7'h36;
  localparam logic [6:0] KeyAlt        = 7'h38;
  localparam logic [6:0] KeyCapsLock   = 7'h3A;

  // Character bounds and offsets for letter folding.
  localparam logic [7:0] ChLowerA   = 8'h61;
  localparam logic [7:0] ChLowerZ   = 8'h7A;
  localparam logic [7:0] ChUpperA   = 8'h41;
  localparam logic [7:0] ChUpperZ   = 8'h5A;
  localparam logic [7:0] CaseOffset = 8'd32;
  localparam logic [7:0] LowerToCtl = 8'h60;
  localparam logic [7:0] UpperToCtl = 8'h40;

  // Character for a make code with Shift released.
  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    case (key)
      7'd2:  ch = 8'h31;
      7'd3:  ch = 8'h32;
      7'd4:  ch = 8'h33;
      7'd5:  ch = 8'h34;
      7'd6:  ch = 8'h35;
      7'd7:  ch = 8'h36;
      7'd8:  ch = 8'h37;
      7'd9:  ch = 8'h38;
      7'd10: ch = 8'h39;
      7'd11: ch = 8'h30;
      7'd12: ch = 8'h2D;
      7'd13: ch = 8'h3D;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h71;
      7'd17: ch = 8'h77;
      7'd18: ch = 8'h65;
      7'd19: ch = 8'h72;
      7'd20: ch = 8'h74;
      7'd21: ch = 8'h79;
      7'd22: ch = 8'h75;
      7'd23: ch = 8'h69;
      7'd24: ch = 8'h6F;
      7'd25: ch = 8'h70;
      7'd26: ch = 8'h5B;
      7'd27: ch = 8'h5D;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h61;
      7'd31: ch = 8'h73;
      7'd32: ch = 8'h64;
      7'd33: ch = 8'h66;
      7'd34: ch = 8'h67;
      7'd35: ch = 8'h68;
      7'd36: ch = 8'h6A;
      7'd37: ch = 8'h6B;
      7'd38: ch = 8'h6C;
      7'd39: ch = 8'h3B;
      7'd40: ch = 8'h27;
      7'd41: ch = 8'h60;
      7'd43: ch = 8'h5C;
      7'd44: ch = 8'h7A;
      7'd45: ch = 8'h78;
      7'd46: ch = 8'h63;
      7'd47: ch = 8'h76;
      7'd48: ch = 8'h62;
      7'd49: ch = 8'h6E;
      7'd50: ch = 8'h6D;
      7'd51: ch = 8'h2C;
      7'd52: ch = 8'h2E;
      7'd53: ch = 8'h2F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      7'd74: ch = 8'h2D;
      7'd78: ch = 8'h2B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character for a make code with Shift held.
  function automatic logic [7:0] shift_char(input logic [6:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    case (key)
      7'd2:  ch = 8'h21;
      7'd3:  ch = 8'h40;
      7'd4:  ch = 8'h23;
      7'd5:  ch = 8'h24;
      7'd6:  ch = 8'h25;
      7'd7:  ch = 8'h5E;
      7'd8:  ch = 8'h26;
      7'd9:  ch = 8'h2A;
      7'd10: ch = 8'h28;
      7'd11: ch = 8'h29;
      7'd12: ch = 8'h5F;
      7'd13: ch = 8'h2B;
      7'd14: ch = 8'h08;
      7'd15: ch = 8'h09;
      7'd16: ch = 8'h51;
      7'd17: ch = 8'h57;
      7'd18: ch = 8'h45;
      7'd19: ch = 8'h52;
      7'd20: ch = 8'h54;
      7'd21: ch = 8'h59;
      7'd22: ch = 8'h55;
      7'd23: ch = 8'h49;
      7'd24: ch = 8'h4F;
      7'd25: ch = 8'h50;
      7'd26: ch = 8'h7B;
      7'd27: ch = 8'h7D;
      7'd28: ch = 8'h0A;
      7'd30: ch = 8'h41;
      7'd31: ch = 8'h53;
      7'd32: ch = 8'h44;
      7'd33: ch = 8'h46;
      7'd34: ch = 8'h47;
      7'd35: ch = 8'h48;
      7'd36: ch = 8'h4A;
      7'd37: ch = 8'h4B;
      7'd38: ch = 8'h4C;
      7'd39: ch = 8'h3A;
      7'd40: ch = 8'h22;
      7'd41: ch = 8'h7E;
      7'd43: ch = 8'h7C;
      7'd44: ch = 8'h5A;
      7'd45: ch = 8'h58;
      7'd46: ch = 8'h43;
      7'd47: ch = 8'h56;
      7'd48: ch = 8'h42;
      7'd49: ch = 8'h4E;
      7'd50: ch = 8'h4D;
      7'd51: ch = 8'h3C;
      7'd52: ch = 8'h3E;
      7'd53: ch = 8'h3F;
      7'd55: ch = 8'h2A;
      7'd57: ch = 8'h20;
      7'd74: ch = 8'h2D;
      7'd78: ch = 8'h2B;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scancode_set1_to_ascii_queue_core.sv =====
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_queue_core
// Set 1 keyboard scancode decoder with modifier tracking and a character ring.
// ----------------------------------------------------------------------------
// Each input item is either a raw Set 1 scancode byte (mode 0) or a request to
// pop one queued character (mode 1), and each item yields exactly one result
// item. The block takes one item per clock cycle while out_stall_i is low, and
// each item passes through the input register and then the result register,
// with table lookup, modifier logic and ring update in between. The character
// ring is a RingDepth x 8 memory with one write and one registered read port;
// it holds up to RingDepth-1 characters, and a character that arrives while it
// is full is dropped. The ring needs no clearing pass after reset. The four
// arrow key codes are written through the configuration port, which is always
// ready; write it only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module scancode_set1_to_ascii_queue_core #(
  parameter int unsigned RingDepth = sc1aq_pkg::RingDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  sc1aq_pkg::cfg_reg_e      cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  // Input item channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [7:0]               scancode_i,
  // Result item channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               read_char_o,
  output logic                     read_valid_o,
  output logic                     char_waiting_o,
  output logic                     ctrl_held_o,
  output logic                     alt_is_held_o,
  output logic                     scroll_up_event_o,
  output logic                     scroll_down_event_o
);

  import sc1aq_pkg::*;

  localparam int unsigned IdxW = $clog2(RingDepth);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(RingDepth - 1);

  // Configuration registers
  logic [7:0] up_code_q, down_code_q, left_code_q, right_code_q;

  // Input register
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic [7:0] s1_code_q;

  // Decoder state
  logic [IdxW-1:0] rd_idx_q, rd_idx_d, wr_idx_q, wr_idx_d;
  logic shift_q, shift_d, caps_q, caps_d, ext_q, ext_d, ctrl_q, ctrl_d, alt_q, alt_d;

  // Result register
  logic       out_valid_q;
  logic       rvalid_q, waiting_q, ctrl_out_q, alt_out_q, up_ev_q, down_ev_q;
  logic [7:0] rd_data_q;

  // Character ring
  logic [7:0] ring_q [RingDepth];

  // Handshake and datapath controls
  logic            in_accept, advance;
  logic            push_req, push_en, pop_en, ring_full, ring_empty;
  logic            up_req, down_req;
  logic [7:0]      push_char, look_char, fold_char;
  logic [6:0]      key;
  logic [IdxW-1:0] wr_next, rd_next;

  // Item moves from the input register to the result register when the
  // result register is empty or its item is taken in this cycle.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_code_q    <= UpArrowReset;
      down_code_q  <= DownArrowReset;
      left_code_q  <= LeftArrowReset;
      right_code_q <= RightArrowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgUpArrow:    up_code_q    <= cfg_data_i;
        CfgDownArrow:  down_code_q  <= cfg_data_i;
        CfgLeftArrow:  left_code_q  <= cfg_data_i;
        CfgRightArrow: right_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ring pointer arithmetic
  assign wr_next    = (wr_idx_q == IdxLast) ? '0 : wr_idx_q + 1'b1;
  assign rd_next    = (rd_idx_q == IdxLast) ? '0 : rd_idx_q + 1'b1;
  assign ring_full  = (wr_next == rd_idx_q);
  assign ring_empty = (rd_idx_q == wr_idx_q);

  // Table lookup with CapsLock and Ctrl letter folding
  assign key = s1_code_q[6:0];
  always_comb begin
    if (shift_q) begin
      look_char = shift_char(key);
    end else begin
      look_char = plain_char(key);
      if (caps_q && look_char >= ChLowerA && look_char <= ChLowerZ) begin
        look_char = look_char - CaseOffset;
      end
    end
    fold_char = look_char;
    if (ctrl_q && look_char >= ChLowerA && look_char <= ChLowerZ) begin
      fold_char = look_char - LowerToCtl;
    end else if (ctrl_q && look_char >= ChUpperA && look_char <= ChUpperZ) begin
      fold_char = look_char - UpperToCtl;
    end
  end

  // Scancode decode: modifier updates and the character to queue
  always_comb begin
    shift_d   = shift_q;
    caps_d    = caps_q;
    ext_d     = ext_q;
    ctrl_d    = ctrl_q;
    alt_d     = alt_q;
    push_req  = 1'b0;
    push_char = fold_char;
    up_req    = 1'b0;
    down_req  = 1'b0;
    if (!s1_mode_q) begin
      if (s1_code_q == ScPrefixExt) begin
        ext_d = 1'b1;
      end else if (s1_code_q == ScCtrlMake) begin
        ctrl_d = 1'b1;
      end else if (s1_code_q == ScCtrlBreak) begin
        ctrl_d = 1'b0;
      end else if (ext_q) begin
        // Extended key: only arrow makes queue anything.
        ext_d = 1'b0;
        if (!s1_code_q[7]) begin
          case (key)
            KeyArrowUp: begin
              push_req  = 1'b1;
              push_char = up_code_q;
              up_req    = 1'b1;
            end
            KeyArrowDown: begin
              push_req  = 1'b1;
              push_char = down_code_q;
              down_req  = 1'b1;
            end
            KeyArrowLeft: begin
              push_req  = 1'b1;
              push_char = left_code_q;
            end
            KeyArrowRight: begin
              push_req  = 1'b1;
              push_char = right_code_q;
            end
            default: ;
          endcase
        end
      end else if (s1_code_q[7]) begin
        // Plain break code: release Shift or Alt.
        if (key == KeyShiftLeft || key == KeyShiftRight) begin
          shift_d = 1'b0;
        end
        if (key == KeyAlt) begin
          alt_d = 1'b0;
        end
      end else if (key == KeyShiftLeft || key == KeyShiftRight) begin
        shift_d = 1'b1;
      end else if (key == KeyAlt) begin
        alt_d = 1'b1;
      end else if (key == KeyCapsLock) begin
        caps_d = !caps_q;
      end else if (s1_code_q < 8'(TableEntries)) begin
        push_req = (fold_char != 8'h00);
      end
    end
  end

  // Ring access for the item in the input register
  assign push_en  = advance && push_req && !ring_full;
  assign pop_en   = advance && s1_mode_q && !ring_empty;
  assign wr_idx_d = push_en ? wr_next : wr_idx_q;
  assign rd_idx_d = pop_en ? rd_next : rd_idx_q;

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      ring_q[wr_idx_q] <= push_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_en) begin
      rd_data_q <= ring_q[rd_idx_q];
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= mode_i;
      s1_code_q <= scancode_i;
    end
  end

  // Decoder state, updated as each item passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      ext_q    <= 1'b0;
      ctrl_q   <= 1'b0;
      alt_q    <= 1'b0;
    end else if (advance) begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      shift_q  <= shift_d;
      caps_q   <= caps_d;
      ext_q    <= ext_d;
      ctrl_q   <= ctrl_d;
      alt_q    <= alt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rvalid_q   <= pop_en;
      waiting_q  <= (rd_idx_d != wr_idx_d);
      ctrl_out_q <= ctrl_d;
      alt_out_q  <= alt_d;
      up_ev_q    <= up_req && push_en;
      down_ev_q  <= down_req && push_en;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_char_o         = rvalid_q ? rd_data_q : 8'h00;
  assign read_valid_o        = rvalid_q;
  assign char_waiting_o      = waiting_q;
  assign ctrl_held_o         = ctrl_out_q;
  assign alt_is_held_o       = alt_out_q;
  assign scroll_up_event_o   = up_ev_q;
  assign scroll_down_event_o = down_ev_q;

  // A pop from a non-empty ring must show up as a valid read.
  `SC_ASSERT(a_pop_reports, advance && s1_mode_q && !ring_empty |=> rvalid_q, "pop lost")
  // A scancode item never reports a read.
  `SC_ASSERT(a_scan_no_read, advance && !s1_mode_q |=> !rvalid_q, "read on scancode")
  // A scroll event means a character was just queued.
  `SC_ASSERT_NEVER(a_scroll_waiting, out_valid_q && (up_ev_q || down_ev_q) && !waiting_q,
                   "scroll event with empty ring")
  // Up and down scroll events come from one byte and cannot coincide.
  `SC_ASSERT_NEVER(a_scroll_excl, out_valid_q && up_ev_q && down_ev_q, "both scroll events")

endmodule

`default_nettype wire
